### sv/biquad_cascade_equalizer_assert.svh
// ----------------------------------------------------------------------------
// Equalizer assertion macros
// Concurrent assertion shorthands, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_EQUALIZER_ASSERT_SVH
`define BIQUAD_CASCADE_EQUALIZER_ASSERT_SVH

// same-cycle implication
`define BQE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BQE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bqe_pkg.sv
// ----------------------------------------------------------------------------
// Equalizer package
// Payload types, codes, defaults and sample format helpers.
// ----------------------------------------------------------------------------
package bqe_pkg;

  localparam int BANDS_DEF       = 10;
  localparam int MAX_CHANS_DEF   = 2;
  localparam int COEF_WIDTH_DEF  = 32;
  localparam int STATE_WIDTH_DEF = 40;
  localparam int DIG_W           = 8;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  localparam logic REG_SAMPLE_FORMAT = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  localparam logic [2:0] FMT_S8  = 3'd0;
  localparam logic [2:0] FMT_U8  = 3'd1;
  localparam logic [2:0] FMT_S16 = 3'd2;
  localparam logic [2:0] FMT_U16 = 3'd3;
  localparam logic [2:0] FMT_S32 = 3'd4;
  localparam logic [2:0] FMT_U32 = 3'd5;

  typedef struct packed {
    logic               operation;
    logic [31:0]        raw_sample;
    logic               buffer_start;
    logic [3:0]         band_index;
    logic [2:0]         coef_select;
    logic signed [31:0] coef_value;
  } bqe_in_t;

  typedef struct packed {
    logic [31:0] out_sample;
    logic        clamped;
  } bqe_out_t;

  typedef struct packed {
    logic       en;
    logic [2:0] sel;
  } coef_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_CASC,
    ST_MUL,
    ST_OUT
  } top_state_e;

  function automatic logic fmt_ok(input logic [2:0] f);
    return f <= FMT_U32;
  endfunction

  function automatic logic fmt_is_signed(input logic [2:0] f);
    return (f == FMT_S8) || (f == FMT_S16) || (f == FMT_S32);
  endfunction

  function automatic logic [31:0] fmt_max(input logic [2:0] f);
    case (f)
      FMT_S8:  return 32'd127;
      FMT_U8:  return 32'd255;
      FMT_S16: return 32'd32767;
      FMT_U16: return 32'd65535;
      FMT_S32: return 32'h7FFF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] fmt_mask(input logic [2:0] f);
    case (f)
      FMT_S8, FMT_U8:   return 32'h0000_00FF;
      FMT_S16, FMT_U16: return 32'h0000_FFFF;
      default:          return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic signed [32:0] sample_sext(input logic [2:0] f,
                                                     input logic [31:0] r);
    case (f)
      FMT_S8:  return 33'($signed(r[7:0]));
      FMT_S16: return 33'($signed(r[15:0]));
      default: return 33'($signed(r));
    endcase
  endfunction

endpackage

### sv/bqe_stream_if.sv
// ----------------------------------------------------------------------------
// Equalizer stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bqe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/biquad_cascade_equalizer.sv
// ----------------------------------------------------------------------------
// Biquad cascade equalizer
// Normalizes integer samples, runs them through a chain of biquad cells
// with per-channel state, clamps and converts back to the sample format.
// ----------------------------------------------------------------------------
//  channel  | role | payload
//  in_i     | sink | operation, raw_sample, buffer_start, band_index,
//           |      | coef_select, coef_value
//  out_o    | src  | out_sample, clamped
//  cfg_*_i  | wr   | sample_format (index 0), channel_count (index 1)
//
// Coefficient writes are taken in the idle state. A sample passes the
// normalizer, then the chain of BANDS cells (one 8-bit digit multiplier
// per cell), then the product and output registers of the conversion; the
// next transaction can be taken in the cycle in which out_o turns valid.
// Reset clears all delay state at once; coefficients must be written first.
// Input stalls while a sample is in flight; a full output register holds
// the conversion until out_o is taken.
// ----------------------------------------------------------------------------
module biquad_cascade_equalizer import bqe_pkg::*; #(
  parameter int BANDS       = BANDS_DEF,
  parameter int MAX_CHANS   = MAX_CHANS_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [2:0]       cfg_data_i,
  bqe_stream_if.sink       in_i,
  bqe_stream_if.source     out_o
);

  localparam int LW = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;
  localparam logic signed [64:0] ONE65 = 65'sd1 <<< 30;

  top_state_e              state_q, state_d;
  logic [2:0]              fmt_q;
  logic [1:0]              cc_q;
  logic [LW-1:0]           cnt_q, lane_q;
  logic                    in_ready, acc_in, go_sample, wr_coef;
  int                      eff, cnt_int, lane_int, nxt_int;
  logic [COEF_WIDTH-1:0]   cw_val;
  logic                    norm_done;
  logic signed [STATE_WIDTH-1:0] norm_x;

  logic                          c_start [BANDS+1];
  logic signed [STATE_WIDTH-1:0] c_x [BANDS+1];
  logic [LW-1:0]                 c_lane [BANDS+1];

  logic signed [64:0]      y65;
  logic signed [31:0]      yc;
  logic                    clip_d, clip_q;
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      prod_q, prod_rnd;
  logic [31:0]             pat;
  logic                    out_vld_q, out_load;
  bqe_out_t                out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_S16;
      cc_q  <= 2'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SAMPLE_FORMAT) begin
        fmt_q <= cfg_data_i;
      end else begin
        cc_q <= cfg_data_i[1:0];
      end
    end
  end

  always_comb begin
    eff      = (cc_q == 2'd0) ? 1 : ((int'(cc_q) > MAX_CHANS) ? MAX_CHANS : int'(cc_q));
    cnt_int  = int'(cnt_q);
    lane_int = (in_i.payload.buffer_start || cnt_int >= eff) ? 0 : cnt_int;
    nxt_int  = (lane_int + 1 >= eff) ? 0 : lane_int + 1;
  end

  generate
    if (COEF_WIDTH >= 32) begin : g_cup
      assign cw_val = COEF_WIDTH'(in_i.payload.coef_value) << (COEF_WIDTH - 32);
    end else begin : g_cdn
      assign cw_val = in_i.payload.coef_value[31 -: COEF_WIDTH];
    end
  endgenerate

  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    go_sample = 1'b0;
    wr_coef   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.payload.operation == OP_COEF) begin
            wr_coef = int'(in_i.payload.band_index) < BANDS &&
                      in_i.payload.coef_select <= COEF_A2;
          end else if (fmt_ok(fmt_q)) begin
            go_sample = 1'b1;
            state_d   = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          state_d = ST_CASC;
        end
      end
      ST_CASC: begin
        if (c_start[BANDS]) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign acc_in     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (go_sample) begin
        cnt_q <= LW'(nxt_int);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_sample) begin
      lane_q <= LW'(lane_int);
    end
  end

  bqe_norm #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_sample),
    .fmt_i   (fmt_q),
    .raw_i   (in_i.payload.raw_sample),
    .done_o  (norm_done),
    .x_o     (norm_x)
  );

  assign c_start[0] = norm_done;
  assign c_x[0]     = norm_x;
  assign c_lane[0]  = lane_q;

  generate
    for (genvar b = 0; b < BANDS; b++) begin : g_cell
      coef_wr_t cw;
      assign cw.en  = wr_coef && (int'(in_i.payload.band_index) == b);
      assign cw.sel = in_i.payload.coef_select;
      bqe_cell #(
        .MAX_CHANS   (MAX_CHANS),
        .COEF_WIDTH  (COEF_WIDTH),
        .STATE_WIDTH (STATE_WIDTH),
        .LW          (LW)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .cw_i    (cw),
        .cval_i  (cw_val),
        .start_i (c_start[b]),
        .x_i     (c_x[b]),
        .lane_i  (c_lane[b]),
        .done_o  (c_start[b+1]),
        .y_o     (c_x[b+1]),
        .lane_o  (c_lane[b+1])
      );
    end
  endgenerate

  always_comb begin
    y65    = 65'(c_x[BANDS]);
    clip_d = 1'b0;
    yc     = 32'(y65);
    if (y65 > ONE65) begin
      yc     = 32'sd1 <<< 30;
      clip_d = 1'b1;
    end else if (y65 < -ONE65) begin
      yc     = -(32'sd1 <<< 30);
      clip_d = 1'b1;
    end
    mul_a = fmt_is_signed(fmt_q) ? 33'(yc) : 33'(yc) + (33'sd1 <<< 30);
    mul_b = $signed({1'b0, fmt_max(fmt_q)});
    if (fmt_is_signed(fmt_q)) begin
      prod_rnd = prod_q[65] ? (prod_q + ((66'sd1 <<< 30) - 66'sd1)) >>> 30
                            : prod_q >>> 30;
    end else begin
      prod_rnd = $signed(66'(prod_q) >> 31);
    end
    pat = prod_rnd[31:0] & fmt_mask(fmt_q);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CASC && c_start[BANDS]) begin
      prod_q <= mul_a * mul_b;
      clip_q <= clip_d;
    end
    if (out_load) begin
      out_q.out_sample <= pat;
      out_q.clamped    <= clip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  `include "biquad_cascade_equalizer_assert.svh"

  `BQE_ASSERT_IMPL(a_norm_state, norm_done, state_q == ST_NORM, "normalizer done outside NORM")
  `BQE_ASSERT_IMPL(a_casc_state, c_start[BANDS], state_q == ST_CASC, "chain done outside CASC")
  `BQE_ASSERT_NEXT(a_go_norm, acc_in && go_sample, state_q == ST_NORM, "sample did not start")
  `BQE_ASSERT_IMPL(a_load_room, out_load, !out_vld_q || out_o.ready, "output overwritten")

endmodule

### sv/bqe_norm.sv
// ----------------------------------------------------------------------------
// Equalizer input normalizer
// Scales a raw sample to Q1.30; the division by 2^k - 1 folds the high part
// of the remainder onto the low part, one fold per cycle.
// ----------------------------------------------------------------------------
module bqe_norm import bqe_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [2:0]                    fmt_i,
  input  logic [31:0]                   raw_i,
  output logic                          done_o,
  output logic signed [STATE_WIDTH-1:0] x_o
);

  localparam int NIT = 16;
  localparam logic signed [64:0] SMAX = (65'sd1 <<< (STATE_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] SMIN = -(65'sd1 <<< (STATE_WIDTH - 1));

  logic                          busy_q;
  logic [3:0]                    cnt_q;
  logic                          sgn_q, neg_q;
  logic [5:0]                    k_q, k_d;
  logic [63:0]                   msk_q, q_q, r_q, q_d, r_d, t, qf;
  logic                          done_q;
  logic signed [STATE_WIDTH-1:0] x_q, x_d;
  logic signed [32:0]            s_ext, s_mag;
  logic signed [33:0]            xs;
  logic signed [64:0]            xw;

  always_comb begin
    s_ext = sample_sext(fmt_i, raw_i);
    s_mag = s_ext[32] ? -s_ext : s_ext;
    case (fmt_i)
      FMT_S8:  k_d = 6'd7;
      FMT_U8:  k_d = 6'd8;
      FMT_S16: k_d = 6'd15;
      FMT_U16: k_d = 6'd16;
      FMT_S32: k_d = 6'd31;
      default: k_d = 6'd32;
    endcase
    t   = r_q >> k_q;
    r_d = (r_q & msk_q) + t;
    q_d = q_q + t;
    qf  = (r_d == msk_q) ? q_d + 64'd1 : q_d;
    if (sgn_q) begin
      xs = neg_q ? -$signed({1'b0, qf[32:0]}) : $signed({1'b0, qf[32:0]});
    end else begin
      xs = $signed({1'b0, qf[32:0]}) - (34'sd1 <<< 30);
    end
    xw = 65'(xs);
    if (xw > SMAX) begin
      x_d = SMAX[STATE_WIDTH-1:0];
    end else if (xw < SMIN) begin
      x_d = SMIN[STATE_WIDTH-1:0];
    end else begin
      x_d = xw[STATE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(NIT - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sgn_q <= fmt_is_signed(fmt_i);
      neg_q <= fmt_is_signed(fmt_i) && s_ext[32];
      k_q   <= k_d;
      msk_q <= 64'(fmt_max(fmt_i));
      q_q   <= '0;
      r_q   <= fmt_is_signed(fmt_i) ? (64'(s_mag[31:0]) << 30)
                                    : (64'(raw_i & fmt_mask(fmt_i)) << 31);
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
      if (cnt_q == 4'(NIT - 1)) begin
        x_q <= x_d;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;

endmodule

### sv/bqe_cell.sv
// ----------------------------------------------------------------------------
// Equalizer band cell
// One biquad section: own coefficients and per-channel delay line,
// digit-serial multiply-accumulate, result handed to the next cell.
// ----------------------------------------------------------------------------
module bqe_cell import bqe_pkg::*; #(
  parameter int MAX_CHANS   = MAX_CHANS_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
  parameter int STATE_WIDTH = STATE_WIDTH_DEF,
  parameter int LW          = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  coef_wr_t                      cw_i,
  input  logic [COEF_WIDTH-1:0]         cval_i,
  input  logic                          start_i,
  input  logic signed [STATE_WIDTH-1:0] x_i,
  input  logic [LW-1:0]                 lane_i,
  output logic                          done_o,
  output logic signed [STATE_WIDTH-1:0] y_o,
  output logic [LW-1:0]                 lane_o
);

  localparam int ND  = (COEF_WIDTH + DIG_W - 1) / DIG_W;
  localparam int CE  = ND * DIG_W;
  localparam int PW  = STATE_WIDTH + DIG_W + 1;
  localparam int AW  = CE + STATE_WIDTH + 3;
  localparam int CF  = COEF_WIDTH - 4;
  localparam int DCW = (ND > 1) ? $clog2(ND) : 1;

  logic [COEF_WIDTH-1:0]         coef_q [5];
  logic signed [STATE_WIDTH-1:0] dly_q [MAX_CHANS][4];

  logic                          busy_q, iss_done_q, p_vld_q, done_q;
  logic [2:0]                    term_q;
  logic [DCW-1:0]                dig_q, p_sh_q;
  logic signed [STATE_WIDTH-1:0] x_q, y_q, y_d, op;
  logic [LW-1:0]                 lane_q;
  logic signed [AW-1:0]          acc_q, addend;
  logic signed [PW-1:0]          p_q;
  logic                          p_neg_q, neg;
  logic [COEF_WIDTH-1:0]         coef;
  logic signed [CE-1:0]          cext;
  logic signed [DIG_W:0]         dig9;
  logic                          last_dig;
  logic [AW-CF-STATE_WIDTH:0]    hi;

  always_comb begin
    coef = coef_q[0];
    op   = x_q;
    neg  = 1'b0;
    case (term_q)
      COEF_B0: begin
        coef = coef_q[0];
        op   = x_q;
      end
      COEF_B1: begin
        coef = coef_q[1];
        op   = dly_q[lane_q][0];
      end
      COEF_B2: begin
        coef = coef_q[2];
        op   = dly_q[lane_q][1];
      end
      COEF_A1: begin
        coef = coef_q[3];
        op   = dly_q[lane_q][2];
        neg  = 1'b1;
      end
      COEF_A2: begin
        coef = coef_q[4];
        op   = dly_q[lane_q][3];
        neg  = 1'b1;
      end
      default: begin
        coef = coef_q[0];
        op   = x_q;
      end
    endcase
    cext     = CE'($signed(coef));
    last_dig = int'(dig_q) == ND - 1;
    dig9     = last_dig ? $signed({cext[int'(dig_q)*DIG_W + DIG_W - 1],
                                   cext[int'(dig_q)*DIG_W +: DIG_W]})
                        : $signed({1'b0, cext[int'(dig_q)*DIG_W +: DIG_W]});
    addend   = AW'(p_q) <<< (DIG_W * int'(p_sh_q));
    hi       = acc_q[AW-1:CF+STATE_WIDTH-1];
    if (&hi || ~|hi) begin
      y_d = acc_q[CF+STATE_WIDTH-1:CF];
    end else if (acc_q[AW-1]) begin
      y_d = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    end else begin
      y_d = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_i.en) begin
      coef_q[cw_i.sel] <= cval_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      iss_done_q <= 1'b0;
      p_vld_q    <= 1'b0;
      done_q     <= 1'b0;
      term_q     <= '0;
      dig_q      <= '0;
      for (int c = 0; c < MAX_CHANS; c++) begin
        for (int k = 0; k < 4; k++) begin
          dly_q[c][k] <= '0;
        end
      end
    end else begin
      done_q  <= 1'b0;
      p_vld_q <= 1'b0;
      if (start_i) begin
        busy_q     <= 1'b1;
        iss_done_q <= 1'b0;
        term_q     <= COEF_B0;
        dig_q      <= '0;
      end else if (busy_q && !iss_done_q) begin
        p_vld_q <= 1'b1;
        if (last_dig) begin
          dig_q <= '0;
          if (term_q == COEF_A2) begin
            iss_done_q <= 1'b1;
          end else begin
            term_q <= term_q + 3'd1;
          end
        end else begin
          dig_q <= dig_q + DCW'(1);
        end
      end else if (busy_q && !p_vld_q) begin
        busy_q             <= 1'b0;
        done_q             <= 1'b1;
        dly_q[lane_q][1]   <= dly_q[lane_q][0];
        dly_q[lane_q][0]   <= x_q;
        dly_q[lane_q][3]   <= dly_q[lane_q][2];
        dly_q[lane_q][2]   <= y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      lane_q <= lane_i;
      acc_q  <= '0;
    end else if (p_vld_q) begin
      acc_q <= p_neg_q ? acc_q - addend : acc_q + addend;
    end
    if (busy_q && !iss_done_q) begin
      p_q     <= dig9 * op;
      p_sh_q  <= dig_q;
      p_neg_q <= neg;
    end
    if (busy_q && iss_done_q && !p_vld_q) begin
      y_q <= y_d;
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;
  assign lane_o = lane_q;

  `include "biquad_cascade_equalizer_assert.svh"

  `BQE_ASSERT_IMPL(a_start_idle, start_i, !busy_q, "cell started while busy")
  `BQE_ASSERT_NEXT(a_done_pulse, done_q, !done_q && !busy_q, "cell done not a single pulse")
  `BQE_ASSERT_IMPL(a_prod_busy, p_vld_q, busy_q, "product pending while cell idle")

endmodule
